>>> design/assert_macros.svh
// Assertion macros shared by the planner RTL.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> design/ftp_pkg.sv
// Package for the fixed timestep planner: field widths, constants and shared types.
// Used by ftp_divider and fixed_timestep_planner; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ftp_pkg;

   // Field widths fixed by the interface.
   localparam int TARGET_BITS = 31;
   localparam int GAP_BITS    = 16;   // frame length, drift limit, step width
   localparam int STEP_BITS   = 10;   // step period register
   localparam int INDEX_BITS  = 5;
   localparam int STREAK_BITS = 5;

   // Register reset values.
   localparam logic [STEP_BITS-1:0] STEP_PERIOD_RESET = 10'd3;
   localparam logic [GAP_BITS-1:0]  DRIFT_LIMIT_RESET = 16'd500;

   // Starved streak handling.
   localparam logic [STREAK_BITS-1:0] STARVE_LIMIT = 5'd30;
   localparam logic [STREAK_BITS-1:0] STREAK_MAX   = 5'd31;

   // Status of the shared divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

>>> design/ftp_divider.sv
// Shared shift-subtract divider: one quotient bit per cycle, GAP_BITS bits per division.
// Depends on ftp_pkg for widths and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module ftp_divider
   import ftp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [GAP_BITS-1:0]  dividend,
   input  wire logic [STEP_BITS-1:0] divisor,
   output logic [GAP_BITS-1:0]       quotient,
   output logic [STEP_BITS-1:0]      remainder,
   output div_status_type            status
);

   localparam int CW = $clog2(GAP_BITS);

   logic [GAP_BITS-1:0]  quo_ff, quo_in;
   logic [STEP_BITS-1:0] rem_ff, rem_in;
   logic [STEP_BITS-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [STEP_BITS:0]   rem_shift;
   logic [STEP_BITS:0]   trial;
   logic                 fits;

   // The partial remainder stays below the divisor, so the shifted value is
   // below twice the divisor and the sign of the trial difference decides.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[GAP_BITS-1]};
      trial     = rem_shift - {1'b0, dsr_ff};
      fits      = !trial[STEP_BITS];

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[GAP_BITS-2:0], fits};
         rem_in = fits ? trial[STEP_BITS-1:0] : rem_shift[STEP_BITS-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(GAP_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

>>> design/fixed_timestep_planner.sv
// Fixed timestep planner: the top level with the frame sequencer, step emitter and CSRs.
// Depends on ftp_pkg, ftp_divider and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Usage. Frames enter on the req_ stream, one word each: target time and frame
// length in req_tdata, the restart flag in req_tuser. Each frame produces zero to
// MAX_STEPS step words on the rsp_ stream; rsp_tlast marks the last step of a
// frame, and rsp_tuser carries the starved and alarm flags.
// The block handles one frame at a time: req_tready is high only while idle.
// After acceptance it works out the clock-to-target gap in S_DIFF, S_MAG and S_CHK
// (twice when the virtual clock reseeds), then the shared shift-subtract divider
// finds the whole steps owed, then S_PLAN and S_LOAD plan the run and load the
// first step word. The following ones come one per cycle while the receiver keeps
// rsp_tready high; the divide is the longest part of the work before the first step.
// A frame that owes no step returns to idle from S_CHK, or from S_PLAN after the divide.
// The step words sit in an output register; when the receiver holds rsp_tready
// low the word and the sequencer simply wait. Taking the last word frees the
// block in the same edge.
// Reset (synchronous, active high) stops the virtual clock, clears the starved
// streak and loads the step period and drift limit with their defaults.
// Registers: step period at byte address 0, drift limit at byte address 4.
module fixed_timestep_planner
   import ftp_pkg::*;
#(
   parameter int MAX_STEPS = 32,
   parameter int TIME_BITS = 32
)
(
   input  wire logic        clock,
   input  wire logic        reset,

   // Frame input stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // frame_target_time[30:0], frame_length[46:31]
   input  wire logic [0:0]  req_tuser,   // restart[0]

   // Step output stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // step_width[15:0], step_end_time[46:16],
                                         // step_index[51:47]
   output logic             rsp_tlast,   // last_step
   output logic [1:0]       rsp_tuser,   // starved[0], starve_alarm[1]

   // Configuration port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int TB = TIME_BITS;
   localparam int KW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

   // Register indexes, decoded from address bit 2.
   localparam logic REG_STEP_PERIOD = 1'b0;
   localparam logic REG_DRIFT_LIMIT = 1'b1;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_DIFF = 8'b0000_0010,
      S_MAG  = 8'b0000_0100,
      S_CHK  = 8'b0000_1000,
      S_DIV  = 8'b0001_0000,
      S_PLAN = 8'b0010_0000,
      S_LOAD = 8'b0100_0000,
      S_EMIT = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [STEP_BITS-1:0] period_ff, period_in;
   logic [GAP_BITS-1:0]  drift_ff, drift_in;

   // Persistent planner state.
   logic [TB-1:0]          vc_ff, vc_in;
   logic                   started_ff, started_in;
   logic [STREAK_BITS-1:0] streak_ff, streak_in;

   // Frame being worked on.
   logic [TB-1:0]       tgt_ff, tgt_in;
   logic [GAP_BITS-1:0] flen_ff, flen_in;
   logic                restart_ff, restart_in;
   logic                reseeded_ff, reseeded_in;
   logic [TB-1:0]       diff_ff, diff_in;
   logic [TB-1:0]       mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [GAP_BITS-1:0] total_ff, total_in;
   logic [KW-1:0]       cnt_m1_ff, cnt_m1_in;

   // Output register and run position.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [GAP_BITS-1:0] width_ff, width_in;
   logic [TB-1:0]       end_ff, end_in;
   logic [KW-1:0]       k_ff, k_in;
   logic [GAP_BITS-1:0] off_ff, off_in;
   logic                last_ff, last_in;
   logic                starved_ff, starved_in;
   logic                alarm_ff, alarm_in;

   // Divider connections.
   logic                 div_start;
   logic [GAP_BITS-1:0]  div_quo;
   logic [STEP_BITS-1:0] div_rem;
   div_status_type       div_status;

   logic [STEP_BITS-1:0] step;
   logic                 csr_write;
   logic                 reseed;
   logic                 frame_starved;
   logic [KW-1:0]        nk;
   logic [GAP_BITS-1:0]  noff;
   logic                 nlast;

   ftp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (mag_ff[GAP_BITS-1:0]),
      .divisor   (step),
      .quotient  (div_quo),
      .remainder (div_rem),
      .status    (div_status)
   );

   // A zero step period behaves as a period of one.
   assign step      = (period_ff == '0) ? STEP_BITS'(1) : period_ff;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // The clock reseeds once per frame at most; the second gap pass after a
   // reseed only measures the new gap.
   assign reseed = !reseeded_ff &&
                   (!started_ff || restart_ff || (mag_ff > TB'(drift_ff)));

   assign div_start     = (state_ff == S_CHK) && !reseed && !neg_ff;
   assign frame_starved = div_quo > GAP_BITS'(MAX_STEPS);

   // Next step of the run. The running end time advances by one period, and the
   // last step lands on the new virtual clock, which folds any extra whole steps.
   always_comb begin
      nk    = (state_ff == S_LOAD) ? '0 : k_ff + 1'b1;
      noff  = (state_ff == S_LOAD) ? '0 : off_ff + GAP_BITS'(step);
      nlast = (nk == cnt_m1_ff);
   end

   always_comb begin
      state_in     = state_ff;
      period_in    = period_ff;
      drift_in     = drift_ff;
      vc_in        = vc_ff;
      started_in   = started_ff;
      streak_in    = streak_ff;
      tgt_in       = tgt_ff;
      flen_in      = flen_ff;
      restart_in   = restart_ff;
      reseeded_in  = reseeded_ff;
      diff_in      = diff_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      total_in     = total_ff;
      cnt_m1_in    = cnt_m1_ff;
      rsp_valid_in = rsp_valid_ff;
      width_in     = width_ff;
      end_in       = end_ff;
      k_in         = k_ff;
      off_in       = off_ff;
      last_in      = last_ff;
      starved_in   = starved_ff;
      alarm_in     = alarm_ff;

      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_STEP_PERIOD: period_in = csr_pwdata[STEP_BITS-1:0];
            REG_DRIFT_LIMIT: drift_in  = csr_pwdata[GAP_BITS-1:0];
            default:         period_in = period_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               tgt_in      = TB'(req_tdata[TARGET_BITS-1:0]);
               flen_in     = req_tdata[TARGET_BITS +: GAP_BITS];
               restart_in  = req_tuser[0];
               reseeded_in = 1'b0;
               state_in    = S_DIFF;
            end
         end
         S_DIFF: begin
            diff_in  = tgt_ff - vc_ff;
            state_in = S_MAG;
         end
         S_MAG: begin
            neg_in   = diff_ff[TB-1];
            mag_in   = diff_ff[TB-1] ? (~diff_ff + 1'b1) : diff_ff;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (reseed) begin
               vc_in       = tgt_ff - ((flen_ff != '0) ? TB'(flen_ff) : TB'(step));
               started_in  = 1'b1;
               reseeded_in = 1'b1;
               state_in    = S_DIFF;
            end else if (neg_ff) begin
               // Clock ahead of target: nothing owed, and the frame is not starved.
               streak_in = '0;
               state_in  = S_IDLE;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               state_in = S_PLAN;
            end
         end
         S_PLAN: begin
            // Whole steps owed, capped; the cap folds the rest into the last step.
            total_in   = mag_ff[GAP_BITS-1:0] - GAP_BITS'(div_rem);
            cnt_m1_in  = frame_starved ? KW'(MAX_STEPS - 1) : KW'(div_quo - 1'b1);
            end_in     = vc_ff;
            vc_in      = vc_ff + TB'(mag_ff[GAP_BITS-1:0] - GAP_BITS'(div_rem));
            starved_in = frame_starved;
            alarm_in   = frame_starved && (streak_ff == STARVE_LIMIT - 1'b1);
            if (!frame_starved) begin
               streak_in = '0;
            end else if (streak_ff != STREAK_MAX) begin
               streak_in = streak_ff + 1'b1;
            end
            state_in = (div_quo == '0) ? S_IDLE : S_LOAD;
         end
         S_LOAD: begin
            rsp_valid_in = 1'b1;
            k_in         = nk;
            off_in       = noff;
            last_in      = nlast;
            end_in       = nlast ? vc_ff : end_ff + TB'(step);
            width_in     = nlast ? total_ff - noff : GAP_BITS'(step);
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_tready) begin
               if (last_ff) begin
                  rsp_valid_in = 1'b0;
                  state_in     = S_IDLE;
               end else begin
                  k_in     = nk;
                  off_in   = noff;
                  last_in  = nlast;
                  end_in   = nlast ? vc_ff : end_ff + TB'(step);
                  width_in = nlast ? total_ff - noff : GAP_BITS'(step);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         period_ff    <= STEP_PERIOD_RESET;
         drift_ff     <= DRIFT_LIMIT_RESET;
         vc_ff        <= '0;
         started_ff   <= 1'b0;
         streak_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         drift_ff     <= drift_in;
         vc_ff        <= vc_in;
         started_ff   <= started_in;
         streak_ff    <= streak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tgt_ff      <= tgt_in;
      flen_ff     <= flen_in;
      restart_ff  <= restart_in;
      reseeded_ff <= reseeded_in;
      diff_ff     <= diff_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      total_ff    <= total_in;
      cnt_m1_ff   <= cnt_m1_in;
      width_ff    <= width_in;
      end_ff      <= end_in;
      k_ff        <= k_in;
      off_ff      <= off_in;
      last_ff     <= last_in;
      starved_ff  <= starved_in;
      alarm_ff    <= alarm_in;
   end

   // Register read-back.
   always_comb begin
      unique case (csr_paddr[2])
         REG_STEP_PERIOD: csr_prdata = 32'(period_ff);
         REG_DRIFT_LIMIT: csr_prdata = 32'(drift_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, INDEX_BITS'(k_ff), TARGET_BITS'(end_ff), width_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = {alarm_ff, starved_ff};

   // A new frame is only taken once every step word of the last one is gone.
   `ASSERT_IMPLIES(a_idle_no_pending, clock, reset, req_tready, !rsp_tvalid)
   // Taking the last step word frees the block at once.
   `ASSERT_NEXT(a_last_frees, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast,
      req_tready && !rsp_tvalid)
   // Every emitted step covers at least one time unit.
   `ASSERT_IMPLIES(a_width_nonzero, clock, reset, rsp_tvalid, width_ff != '0)
   // The alarm only fires on a starved frame.
   `ASSERT_IMPLIES(a_alarm_starved, clock, reset, rsp_tvalid && alarm_ff, starved_ff)

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for fixed_timestep_planner: frames go in on the req_ stream,
// steps are predicted in the bench and checked word by word on the rsp_ stream.
// Depends on ftp_pkg and the fixed_timestep_planner RTL.
`timescale 1ns / 1ps

module tb
   import ftp_pkg::*;
();

   localparam int MAX_STEPS = 32;
   localparam int TIME_BITS = 32;

   // Register byte addresses on the configuration port.
   localparam logic [2:0] REG_STEP_PERIOD = 3'd0;
   localparam logic [2:0] REG_DRIFT_LIMIT = 3'd4;

   // A zero-step frame goes idle once its gap check or divide is done and a stepping
   // frame frees the block on its last word, so SETTLE_CYCLES covers any leftover work.
   localparam int SETTLE_CYCLES = 60;
   // Roughly 280 frames of up to 32 steps each, with half the cycles stalled, fit well
   // inside this limit, which leaves a wide margin.
   localparam int CYCLE_LIMIT   = 600000;
   localparam int MAX_REPORTS   = 40;

   typedef struct packed {
      logic [GAP_BITS-1:0]    width;
      logic [TARGET_BITS-1:0] end_time;
      logic [INDEX_BITS-1:0]  index;
      logic                   last;
      logic                   starved;
      logic                   alarm;
   } step_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // frame_target_time[30:0], frame_length[46:31]
   logic [0:0]  req_tuser = '0;   // restart[0]

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // step_width[15:0], step_end_time[46:16], step_index[51:47]
   logic        rsp_tlast;        // last_step
   logic [1:0]  rsp_tuser;        // starved[0], starve_alarm[1]

   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   fixed_timestep_planner #(
      .MAX_STEPS(MAX_STEPS),
      .TIME_BITS(TIME_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Bench copy of the planner state and registers, starting from reset values.
   logic [TIME_BITS-1:0]   vclock        = '0;
   logic                   clock_running = 1'b0;
   logic [STREAK_BITS-1:0] streak        = '0;
   logic [STEP_BITS-1:0]   period_q      = STEP_PERIOD_RESET;
   logic [GAP_BITS-1:0]    drift_q       = DRIFT_LIMIT_RESET;

   // Steps predicted but not yet seen, oldest first.
   step_word_type owed_steps[$];

   int unsigned errors = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   logic [TARGET_BITS-1:0] last_target = '0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung block or a lost word ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // Receiver back-pressure; the stall rate is set per phase by the test sequence.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Work out the steps that one accepted frame owes and queue them as expected
   // words. The clock gap is read as a signed value modulo 2^TIME_BITS; a clock
   // that is ahead of the target owes nothing but still clears the streak.
   task automatic plan_frame(input logic [TARGET_BITS-1:0] target,
                             input logic [GAP_BITS-1:0] flen, input logic restart);
      logic [TIME_BITS-1:0] step, diff, span, whole, rest, fold, start, end_at, width;
      logic                 starved, alarm, last;
      int                   count;
      step_word_type        word;
      step = (period_q == '0) ? TIME_BITS'(1) : TIME_BITS'(period_q);
      diff = TIME_BITS'(target) - vclock;
      span = diff[TIME_BITS-1] ? (~diff + 1'b1) : diff;
      if (!clock_running || restart || span > TIME_BITS'(drift_q)) begin
         vclock = TIME_BITS'(target) - ((flen != '0) ? TIME_BITS'(flen) : step);
         clock_running = 1'b1;
         diff = TIME_BITS'(target) - vclock;
      end
      count = 0;
      fold = '0;
      starved = 1'b0;
      alarm = 1'b0;
      if (!diff[TIME_BITS-1]) begin
         whole = diff / step;
         if (whole > MAX_STEPS) begin
            // Cap reached: the last step swallows every further whole step owed.
            rest = diff - MAX_STEPS * step;
            fold = rest - rest % step;
            count = MAX_STEPS;
            starved = 1'b1;
         end else begin
            count = int'(whole);
         end
      end
      start = vclock;
      vclock = start + count * step + fold;

      // The alarm fires only on the frame that takes the streak to the limit;
      // a saturated streak holds without firing again.
      if (starved) begin
         if (streak < STREAK_MAX) begin
            streak = streak + 1'b1;
            alarm = (streak == STARVE_LIMIT);
         end
      end else begin
         streak = '0;
      end

      for (int k = 0; k < count; k++) begin
         last = (k == count - 1);
         width = last ? step + fold : step;
         end_at = last ? vclock : start + (k + 1) * step;
         word.width = (width > 32'hFFFF) ? 16'hFFFF : width[GAP_BITS-1:0];
         word.end_time = end_at[TARGET_BITS-1:0];
         word.index = k[INDEX_BITS-1:0];
         word.last = last;
         word.starved = starved;
         word.alarm = alarm;
         owed_steps.push_back(word);
      end
   endtask

   // Compare every accepted step word with the oldest prediction.
   task automatic check_step_word();
      step_word_type got, want;
      got.width = rsp_tdata[15:0];
      got.end_time = rsp_tdata[46:16];
      got.index = rsp_tdata[51:47];
      got.last = rsp_tlast;
      got.starved = rsp_tuser[0];
      got.alarm = rsp_tuser[1];
      if (owed_steps.size() == 0) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: step word with nothing expected: width %0d end %0d index %0d",
                     $time, got.width, got.end_time, got.index);
      end else begin
         want = owed_steps.pop_front();
         if (got !== want) begin
            errors++;
            // Fields in order: width, end time, index, last, starved, alarm.
            if (errors <= MAX_REPORTS)
               $display("%0t: expected %0d %0d %0d %0b %0b %0b, got %0d %0d %0d %0b %0b %0b",
                        $time, want.width, want.end_time, want.index, want.last,
                        want.starved, want.alarm, got.width, got.end_time, got.index,
                        got.last, got.starved, got.alarm);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_step_word();
   end

   // Offer one frame word and hold it until the block takes it. The valid stays
   // high into the next call unless that call starts with an idle gap.
   task automatic send_frame(input logic [TARGET_BITS-1:0] target,
                             input logic [GAP_BITS-1:0] flen, input logic restart);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, flen, target};
      req_tuser <= restart;
      do @(posedge clock); while (!req_tready);
      plan_frame(target, flen, restart);
      last_target = target;
   endtask

   // Stop sending, let every predicted word arrive, then give the block time to
   // finish any frame that owes nothing.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (owed_steps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write a register, then read it back in the following transfer.
   task automatic set_register(input logic [2:0] addr, input logic [31:0] value);
      logic [31:0] readback, mask;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == REG_STEP_PERIOD) begin
         period_q = value[STEP_BITS-1:0];
         mask = (32'd1 << STEP_BITS) - 1;
      end else begin
         drift_q = value[GAP_BITS-1:0];
         mask = (32'd1 << GAP_BITS) - 1;
      end
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if ((readback & mask) !== (value & mask)) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: register %0d read back, expected %0d, got %0d",
                     $time, addr, value & mask, readback & mask);
      end
   endtask

   // Seeding from a stopped clock, catching up in whole steps, a clock that is
   // already at or ahead of the target, a forced restart and a drift reseed.
   task automatic test_clock_seeding();
      send_frame(31'd1000, 16'd0, 1'b0);
      send_frame(31'd1010, 16'd10, 1'b0);
      send_frame(31'd1009, 16'd5, 1'b0);
      send_frame(31'd1000, 16'd5, 1'b0);
      send_frame(31'd1100, 16'd7, 1'b1);
      send_frame(31'd1700, 16'd50, 1'b0);
   endtask

   // Clock arithmetic across zero and across the sign boundary of the gap,
   // plus the largest target and frame length.
   task automatic test_wraparound();
      send_frame(31'd0, 16'd0, 1'b1);
      send_frame(31'h7FFFFFFF, 16'hFFFF, 1'b1);
      send_frame(31'd0, 16'd5, 1'b1);
      // The clock now sits just below 2^32, so this gap is exactly half the range.
      send_frame(31'h7FFFFFFE, 16'd3, 1'b0);
   endtask

   // Step period of zero with a zero drift limit, then a step period of 1000 with the
   // largest drift limit, where a full-width gap folds into the last step.
   task automatic test_register_extremes();
      wait_idle();
      set_register(REG_STEP_PERIOD, 32'd0);
      set_register(REG_DRIFT_LIMIT, 32'd0);
      send_frame(31'd500, 16'd0, 1'b1);
      send_frame(31'd500, 16'd0, 1'b0);
      send_frame(31'd505, 16'd20, 1'b0);
      wait_idle();
      set_register(REG_STEP_PERIOD, 32'd1000);
      set_register(REG_DRIFT_LIMIT, 32'd65535);
      send_frame(31'd100000, 16'd0, 1'b1);
      send_frame(31'd165535, 16'd0, 1'b0);
      send_frame(31'd231071, 16'd0, 1'b0);
      send_frame(31'd10, 16'd999, 1'b0);
   endtask

   // Starved frames with random content: a streak broken by a clock-ahead frame,
   // a streak that reaches the alarm and saturates, a clean frame that clears it,
   // and a second run up to the alarm.
   task automatic starve_run(input int frames);
      for (int i = 0; i < frames; i++) begin
         if ($urandom_range(3) == 0)
            send_frame(last_target + 31'($urandom_range(70, 3000)),
                       16'($urandom_range(66, 65535)), 1'b1);
         else
            send_frame(last_target + 31'($urandom_range(66, 4000)),
                       16'($urandom_range(0, 65535)), 1'b0);
      end
   endtask

   task automatic test_starve_streak();
      wait_idle();
      set_register(REG_STEP_PERIOD, 32'd2);
      set_register(REG_DRIFT_LIMIT, 32'd65535);
      send_frame(31'($urandom_range(0, 1000000)), 16'd70, 1'b1);
      starve_run(9);
      send_frame(last_target - 31'd10, 16'd4, 1'b0);
      starve_run(32);
      send_frame(last_target + 31'd20, 16'd20, 1'b0);
      starve_run(30);
   endtask

   // One random frame: mostly a steady stream advancing by whole and part steps,
   // the rest restarts, clocks left ahead of the target, and raw noise.
   task automatic random_frame();
      int unsigned step, kind, advance;
      step = (period_q == '0) ? 1 : period_q;
      kind = $urandom_range(99);
      if (kind < 70) begin
         advance = step * $urandom_range(0, 36) + $urandom_range(0, step - 1);
         send_frame(last_target + 31'(advance),
                    ($urandom_range(9) == 0) ? 16'd0 : 16'(advance), 1'b0);
      end else if (kind < 80) begin
         advance = $urandom_range(0, 40 * step);
         send_frame(last_target + 31'(advance), 16'(advance), 1'b1);
      end else if (kind < 88) begin
         send_frame(last_target - 31'($urandom_range(1, 4 * step)),
                    16'($urandom_range(0, 65535)), 1'b0);
      end else begin
         send_frame(31'($urandom), 16'($urandom_range(0, 65535)),
                    1'($urandom_range(1)));
      end
   endtask

   // Four traffic phases with different idling on each side and different
   // register settings, the extremes among them.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 4; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
               set_register(REG_STEP_PERIOD, $urandom_range(1, 10));
               set_register(REG_DRIFT_LIMIT, $urandom_range(100, 65535));
            end
            1: begin
               send_idle_pct = 49;
               recv_stall_pct = 0;
               set_register(REG_STEP_PERIOD, 32'd1000);
               set_register(REG_DRIFT_LIMIT, 32'd65535);
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 49;
               set_register(REG_STEP_PERIOD, 32'd0);
               set_register(REG_DRIFT_LIMIT, 32'd1);
            end
            default: begin
               send_idle_pct = 25;
               recv_stall_pct = 25;
               set_register(REG_STEP_PERIOD, $urandom_range(1, 1000));
               set_register(REG_DRIFT_LIMIT, $urandom_range(0, 65535));
            end
         endcase
         repeat (48) random_frame();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_clock_seeding();
      test_wraparound();
      test_register_extremes();
      test_starve_streak();
      test_random_traffic();
      wait_idle();
      if (errors == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
